[hw/rtl/utf16le_byte_decoder_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef UTF16LE_BYTE_DECODER_MACROS_SVH
`define UTF16LE_BYTE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define U16D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define U16D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/u16d_pkg.sv]
package u16d_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_FIRST     = 2'd0,   // low byte of a unit
        PH_SECOND    = 2'd1,   // high byte of a unit
        PH_LO_FIRST  = 2'd2,   // low byte of the unit after a high surrogate
        PH_LO_SECOND = 2'd3    // high byte of the unit after a high surrogate
    } t_phase;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;

    localparam logic [UNIT_W-1:0] HI_SUR_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HI_SUR_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LO_SUR_FIRST = 16'hDC00;
    localparam logic [UNIT_W-1:0] LO_SUR_LAST  = 16'hDFFF;
    localparam logic [UNIT_W-1:0] CR_UNIT      = 16'h000D;
    localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h010000;
    localparam logic [CP_W-1:0]   CP_MAX       = 21'h10FFFF;

    // Register index (paddr[2])
    localparam logic REG_DELETE_CR = 1'b0;

endpackage

[hw/rtl/utf16le_byte_decoder.sv]
// Channel  | Handshake                | Payload          | Dir
// ---------+--------------------------+------------------+----
// in       | i_in_valid / o_in_ready  | i_in_byte[7:0]   | in
// out      | o_out_valid / i_out_ready| o_code_point[20:0]| out
// config   | psel/penable/pwrite      | paddr, pwdata    | in
//
// One byte accepted per cycle when the output side keeps up.
// A byte passes through the input register, then is decoded into the result register.
// A byte waits in the input register while a held result is not taken.
// i_rst_n (synchronous, active low) returns the decoder to the first-byte phase.
`include "utf16le_byte_decoder_macros.svh"

module utf16le_byte_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    // code point output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_delete_cr;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    u16d_pkg::t_phase    r_phase;
    u16d_pkg::t_phase    n_phase;
    logic [15:0]         r_first_unit;
    logic [15:0]         n_first_unit;
    logic [7:0]          r_second_unit_low;
    logic                r_out_valid;
    logic [20:0]         r_code_point;
    logic [20:0]         n_code_point;
    logic [15:0]         w_unit;
    logic [15:0]         w_lo_unit;
    logic                w_emit;
    logic                w_adv_ok;
    logic                w_consume;
    logic                w_out_load;
    logic                w_cfg_wr;

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == u16d_pkg::REG_DELETE_CR) ? {31'd0, r_delete_cr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delete_cr <= 1'b0;
        end else if (w_cfg_wr && paddr[2] == u16d_pkg::REG_DELETE_CR) begin
            r_delete_cr <= pwdata[0];
        end
    end

    // Handshake: stage 1 moves when the result register is free or draining
    assign w_adv_ok   = !r_out_valid || i_out_ready;
    assign w_consume  = r_in_valid && w_adv_ok;
    assign w_out_load = w_consume && w_emit;
    assign o_in_ready = !r_in_valid || w_adv_ok;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Assembled units
    assign w_unit    = {r_in_byte, r_first_unit[7:0]};
    assign w_lo_unit = {r_in_byte, r_second_unit_low};

    // Phase logic and decode
    always_comb begin
        n_phase      = r_phase;
        n_first_unit = r_first_unit;
        n_code_point = {5'd0, w_unit};
        w_emit       = 1'b0;
        case (r_phase)
            u16d_pkg::PH_FIRST: begin
                n_first_unit = {8'd0, r_in_byte};
                n_phase      = u16d_pkg::PH_SECOND;
            end
            u16d_pkg::PH_SECOND: begin
                n_first_unit = w_unit;
                if (r_delete_cr && w_unit == u16d_pkg::CR_UNIT) begin
                    n_phase = u16d_pkg::PH_FIRST;
                end else if (w_unit inside {[u16d_pkg::HI_SUR_FIRST:u16d_pkg::HI_SUR_LAST]}) begin
                    n_phase = u16d_pkg::PH_LO_FIRST;
                end else begin
                    n_phase = u16d_pkg::PH_FIRST;
                    w_emit  = 1'b1;
                end
            end
            u16d_pkg::PH_LO_FIRST: begin
                n_phase = u16d_pkg::PH_LO_SECOND;
            end
            u16d_pkg::PH_LO_SECOND: begin
                // held unit is a high surrogate: its low 10 bits are the offset
                n_phase      = u16d_pkg::PH_FIRST;
                n_code_point = u16d_pkg::SUPP_BASE
                             + {1'b0, r_first_unit[9:0], w_lo_unit[9:0]};
                w_emit       = w_lo_unit inside
                               {[u16d_pkg::LO_SUR_FIRST:u16d_pkg::LO_SUR_LAST]};
            end
            default: begin
                n_phase = u16d_pkg::PH_FIRST;
            end
        endcase
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u16d_pkg::PH_FIRST;
        end else if (w_consume) begin
            r_phase <= n_phase;
        end
    end

    // Unit storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_unit      <= 16'd0;
            r_second_unit_low <= 8'd0;
        end else if (w_consume) begin
            r_first_unit <= n_first_unit;
            if (r_phase == u16d_pkg::PH_LO_FIRST) begin
                r_second_unit_low <= r_in_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_code_point <= n_code_point;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;

    // Checks
    `U16D_ASSERT_NOW(a_emit_on_second_byte, i_clk, i_rst_n, w_out_load, (r_phase == u16d_pkg::PH_SECOND || r_phase == u16d_pkg::PH_LO_SECOND), "result loaded outside a second-byte phase")
    `U16D_ASSERT_NOW(a_pair_is_supplementary, i_clk, i_rst_n, (w_out_load && r_phase == u16d_pkg::PH_LO_SECOND), (n_code_point >= u16d_pkg::SUPP_BASE && n_code_point <= u16d_pkg::CP_MAX), "surrogate pair decoded outside supplementary range")
    `U16D_ASSERT_NOW(a_bmp_is_not_high_sur, i_clk, i_rst_n, (w_out_load && r_phase == u16d_pkg::PH_SECOND), (n_code_point[15:10] != 6'b110110), "high surrogate given out as a code point")
    `U16D_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, (r_in_valid && !w_adv_ok), (r_in_valid && $stable(r_in_byte)), "stalled byte lost from input register")

endmodule
